[rtl/sector_cache_tag_controller_core_assert.svh]
// Assertion macros used by the back end of the sector cache tag controller.
`ifndef SECTOR_CACHE_TAG_CONTROLLER_CORE_ASSERT_SVH
`define SECTOR_CACHE_TAG_CONTROLLER_CORE_ASSERT_SVH

// Check a consequence in the same cycle; expects clk and rst_n in scope.
`define SCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scc assertion failed");

// Check a consequence in the following cycle; expects clk and rst_n in scope.
`define SCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scc assertion failed");

`endif

[rtl/scc_pkg.sv]
// Shared types and constants of the sector cache tag controller.
package scc_pkg;

  localparam int unsigned CACHE_SLOTS_DEF = 16;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned SECTOR_W        = 32;
  localparam int unsigned SLOT_W          = 4;
  localparam int unsigned OPCODE_W        = 2;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SYNC  = 2'd2;

  typedef enum logic [1:0] {
    REQ_READ,
    REQ_WRITE,
    REQ_SYNC
  } req_kind_t;

  typedef struct packed {
    req_kind_t             kind;
    logic [SECTOR_W-1:0]   sector;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DRAIN,
    ST_RESOLVE,
    ST_SYNC_SCAN,
    ST_SYNC_EMIT
  } back_state_t;

endpackage

[rtl/scc_ram.sv]
// Generic single-port RAM with registered read.
module scc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/scc_front.sv]
// Request front end: accept, classify and queue requests for the back end.
module scc_front import scc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [SECTOR_W-1:0] in_sector,
  output q_head_t             head,
  input  logic                pop
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  req_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          known;
  req_kind_t     kind;
  logic          accept;
  logic          push;
  logic          do_pop;

  always_comb begin
    known = 1'b1;
    kind  = REQ_READ;
    case (in_opcode)
      OP_READ:  kind = REQ_READ;
      OP_WRITE: kind = REQ_WRITE;
      OP_SYNC:  kind = REQ_SYNC;
      default:  known = 1'b0;
    endcase
  end

  assign in_ready = (count_r != CW'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;
  // drop unused opcodes at the door
  assign push     = accept && known;
  assign do_pop   = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{kind: kind, sector: in_sector};
    end
  end

  assign head.valid = (count_r != '0);
  assign head.req   = q_r[rd_ptr_r];

endmodule

[rtl/scc_back.sv]
// Request back end: tag scan, victim choice, sync walk and result register.
`include "sector_cache_tag_controller_core_assert.svh"

module scc_back import scc_pkg::*; #(
  parameter int unsigned CACHE_SLOTS = CACHE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  q_head_t             head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_hit,
  output logic                out_write_back,
  output logic [SECTOR_W-1:0] out_victim_sector,
  output logic                out_fetch,
  output logic                out_last
);

  localparam int unsigned IW  = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int unsigned CW  = $clog2(CACHE_SLOTS + 1);
  localparam int unsigned NRW = $clog2(MAX_RESULTS + 1);

  back_state_t          state_r, state_nxt;
  req_kind_t            kind_r;
  logic [SECTOR_W-1:0]  sector_r;
  logic [CW-1:0]        cnt_r;
  logic [IW-1:0]        cnt_idx;
  logic                 cmp_valid_r;
  logic [IW-1:0]        cmp_idx_r;
  logic                 found_r;
  logic [IW-1:0]        match_r;
  logic                 free_found_r;
  logic [IW-1:0]        lfree_r;
  logic [IW-1:0]        hfree_r;
  logic [SECTOR_W-1:0]  tag0_r;
  logic [NRW-1:0]       nres_r;
  logic [CACHE_SLOTS-1:0] slot_valid_r;
  logic [CACHE_SLOTS-1:0] slot_dirty_r;

  logic                 out_valid_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_hit_r;
  logic                 out_write_back_r;
  logic [SECTOR_W-1:0]  out_victim_r;
  logic                 out_fetch_r;
  logic                 out_last_r;

  logic                 out_free;
  logic                 look_issue;
  logic                 res_fire;
  logic                 sync_fire;
  logic                 sync_issue;
  logic                 scan_done;
  logic                 ram_we;
  logic                 ram_re;
  logic [IW-1:0]        ram_addr;
  logic [SECTOR_W-1:0]  ram_rdata;

  logic [IW-1:0]        sel_idx;
  logic                 sel_wb;
  logic [SECTOR_W-1:0]  sel_victim;
  logic [CACHE_SLOTS-1:0] vd;
  logic [CACHE_SLOTS-1:0] vd_above;
  logic                 sync_last;
  logic [IW+SLOT_W-1:0] sel_wide;
  logic [IW+SLOT_W-1:0] cnt_wide;

  assign cnt_idx   = cnt_r[IW-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign vd        = slot_valid_r & slot_dirty_r;
  assign vd_above  = (vd >> cnt_idx) >> 1;
  assign sync_last = !(|vd_above) || (nres_r == NRW'(MAX_RESULTS - 1));
  assign scan_done = (cnt_r == CW'(CACHE_SLOTS)) || (nres_r == NRW'(MAX_RESULTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          state_nxt = (head.req.kind == REQ_SYNC) ? ST_SYNC_SCAN : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cnt_r == CW'(CACHE_SLOTS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_RESOLVE;
      ST_RESOLVE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SYNC_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end else if (vd[cnt_idx]) begin
          state_nxt = ST_SYNC_EMIT;
        end
      end
      ST_SYNC_EMIT: begin
        if (out_free) begin
          state_nxt = ST_SYNC_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop        = 1'b0;
    look_issue = 1'b0;
    res_fire   = 1'b0;
    sync_fire  = 1'b0;
    sync_issue = 1'b0;
    case (state_r)
      ST_IDLE:      pop        = head.valid;
      ST_LOOK:      look_issue = 1'b1;
      ST_DRAIN:     look_issue = 1'b0;
      ST_RESOLVE:   res_fire   = out_free;
      ST_SYNC_SCAN: sync_issue = !scan_done && vd[cnt_idx];
      ST_SYNC_EMIT: sync_fire  = out_free;
      default:      pop        = 1'b0;
    endcase
  end

  // victim selection for a lookup
  always_comb begin
    if (found_r) begin
      sel_idx = match_r;
    end else if (free_found_r) begin
      sel_idx = (kind_r == REQ_READ) ? lfree_r : hfree_r;
    end else begin
      sel_idx = '0;
    end
    // a dirty victim can only be slot zero, when no slot is free
    sel_wb     = !found_r && slot_valid_r[sel_idx] && slot_dirty_r[sel_idx];
    sel_victim = sel_wb ? tag0_r : '0;
  end

  assign sel_wide = (IW + SLOT_W)'(sel_idx);
  assign cnt_wide = (IW + SLOT_W)'(cnt_idx);

  assign ram_re   = look_issue || sync_issue;
  assign ram_we   = res_fire && !found_r;
  assign ram_addr = ram_we ? sel_idx : cnt_idx;

  scc_ram #(
    .WIDTH (SECTOR_W),
    .DEPTH (CACHE_SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (sector_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      slot_dirty_r <= '0;
      out_valid_r  <= 1'b0;
      cmp_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_valid_r <= look_issue;
      if (res_fire) begin
        slot_valid_r[sel_idx] <= 1'b1;
        if (found_r) begin
          if (kind_r == REQ_WRITE) begin
            slot_dirty_r[sel_idx] <= 1'b1;
          end
        end else begin
          slot_dirty_r[sel_idx] <= (kind_r == REQ_WRITE);
        end
      end
      if (sync_fire) begin
        slot_dirty_r[cnt_idx] <= 1'b0;
      end
      if (res_fire || sync_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r       <= head.req.kind;
      sector_r     <= head.req.sector;
      cnt_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      nres_r       <= '0;
    end
    if (look_issue) begin
      cnt_r <= cnt_r + 1'b1;
      if (!slot_valid_r[cnt_idx]) begin
        if (!free_found_r) begin
          lfree_r <= cnt_idx;
        end
        hfree_r      <= cnt_idx;
        free_found_r <= 1'b1;
      end
    end
    if (cmp_valid_r) begin
      if (slot_valid_r[cmp_idx_r] && (ram_rdata == sector_r) && !found_r) begin
        found_r <= 1'b1;
        match_r <= cmp_idx_r;
      end
      if (cmp_idx_r == '0) begin
        tag0_r <= ram_rdata;
      end
    end
    cmp_idx_r <= cnt_idx;
    if (state_r == ST_SYNC_SCAN && !scan_done && !vd[cnt_idx]) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (sync_fire) begin
      cnt_r  <= cnt_r + 1'b1;
      nres_r <= nres_r + 1'b1;
    end
    if (res_fire) begin
      out_slot_r       <= sel_wide[SLOT_W-1:0];
      out_hit_r        <= found_r;
      out_write_back_r <= sel_wb;
      out_victim_r     <= sel_victim;
      out_fetch_r      <= !found_r && (kind_r == REQ_READ);
      out_last_r       <= 1'b1;
    end
    if (sync_fire) begin
      out_slot_r       <= cnt_wide[SLOT_W-1:0];
      out_hit_r        <= 1'b0;
      out_write_back_r <= 1'b1;
      out_victim_r     <= ram_rdata;
      out_fetch_r      <= 1'b0;
      out_last_r       <= sync_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot          = out_slot_r;
  assign out_hit           = out_hit_r;
  assign out_write_back    = out_write_back_r;
  assign out_victim_sector = out_victim_r;
  assign out_fetch         = out_fetch_r;
  assign out_last          = out_last_r;

  `SCC_ASSERT_NOW(a_fire_needs_room, res_fire || sync_fire, !out_valid_r || out_ready)
  `SCC_ASSERT_NOW(a_sync_slot_dirty, sync_fire, slot_valid_r[cnt_idx] && slot_dirty_r[cnt_idx])
  `SCC_ASSERT_NEXT(a_valid_never_drops, 1'b1, $countones(slot_valid_r) >= $countones($past(slot_valid_r)))
  `SCC_ASSERT_NEXT(a_lookup_fills_slot, res_fire, slot_valid_r != '0)

endmodule

[rtl/sector_cache_tag_controller_core.sv]
// Top level of the sector cache tag controller.
// Usage:
//   Requests enter on in_valid/in_ready with in_opcode (read, write, sync)
//   and in_sector. Unused opcodes are accepted and dropped.
//   Results leave on out_valid/out_ready: one per read or write, one per
//   dirty slot written back by a sync (at most sixteen), out_last on the
//   final result of a request; a sync with nothing dirty gives none.
//   A two-entry request queue separates the front end from the back end,
//   so requests are taken while a result waits in the output register.
//   A read or write scans every tag in the tag RAM, one slot per cycle,
//   then a drain and a resolve state register its result.
//   A sync walks the slots one per cycle and, on each dirty slot, waits
//   in an emit state until the output register is free.
//   The tag RAM read port sets this rate; one request is worked at a time.
//   Reset (rst_n low, synchronous) empties the queue, marks every slot
//   invalid and clean and drops any pending result; no clearing pass runs.
//   When out_ready is low, the result holds and the back end stalls when
//   it has one to give; the queue keeps taking requests until it is full.
module sector_cache_tag_controller_core import scc_pkg::*; #(
  parameter int unsigned CACHE_SLOTS = CACHE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [SECTOR_W-1:0] in_sector,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_hit,
  output logic                out_write_back,
  output logic [SECTOR_W-1:0] out_victim_sector,
  output logic                out_fetch,
  output logic                out_last
);

  q_head_t head;
  logic    pop;

  scc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_sector (in_sector),
    .head      (head),
    .pop       (pop)
  );

  scc_back #(
    .CACHE_SLOTS (CACHE_SLOTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_slot          (out_slot),
    .out_hit           (out_hit),
    .out_write_back    (out_write_back),
    .out_victim_sector (out_victim_sector),
    .out_fetch         (out_fetch),
    .out_last          (out_last)
  );

endmodule
